>>> sv/sfr_pkg.sv
// Shared types and constants for the SBUS frame receiver.
// No dependencies; used by sbus_frame_receiver_top, sfr_unpack and the testbench.
package sfr_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int CH_PER_FRAME  = 16;
    localparam int BUF_AW        = 5;
    localparam int CH_BITS       = 11;
    localparam int ACC_W         = 18;
    localparam int CNT_W         = 5;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_ERR  = 2'd2;

    localparam logic [7:0] HDR_BYTE  = 8'h0F;
    localparam logic [7:0] FOOT_BYTE = 8'h00;
    localparam logic [3:0] FOOT_NIB  = 4'h4;
    localparam logic [7:0] IDLE_MAX  = 8'hFF;

    localparam logic [BUF_AW-1:0] FIRST_POS = 5'd1;
    localparam logic [BUF_AW-1:0] FLAGS_POS = 5'd23;
    localparam logic [BUF_AW-1:0] LAST_POS  = 5'd24;
    localparam logic [BUF_AW-1:0] FULL_POS  = 5'd25;

    localparam logic [CNT_W-1:0] CH_BITS_CNT = 5'd11;
    localparam logic [3:0]       LAST_CH     = 4'd15;

    // Commands from the sequencer to the unpacker.
    typedef struct packed {
        logic clear;
        logic load_flags;
        logic merge;
        logic emit;
    } unp_ctrl_t;

    // Status from the unpacker back to the sequencer.
    typedef struct packed {
        logic has_channel;
        logic out_free;
    } unp_stat_t;

    function automatic logic footer_ok(input logic [7:0] f);
        footer_ok = (f == FOOT_BYTE) || (f[3:0] == FOOT_NIB);
    endfunction

endpackage

>>> sv/sbus_frame_receiver_top.sv
// Top level of the SBUS frame receiver: sequencer, frame buffer RAM and unpacker.
// Depends on sfr_pkg, sfr_ram and sfr_unpack.
//
// Usage: the request channel (req_valid / req_stall, fields req_type and rx_byte)
// carries received bytes, one millisecond ticks and line errors. The result channel
// (res_valid / res_stall) delivers sixteen items per accepted frame, channel 0 first,
// each with its channel index, 11-bit value, the frame's flag byte and a last flag.
// The cfg channel (cfg_valid / cfg_ready / cfg_data) writes the idle gap in ms.
// Ticks, line errors and bytes that do not complete a frame leave the block idle.
// A byte that completes a good frame starts an unpack pass: the flag byte and then
// each data byte is read from the frame buffer and merged into the unpacker, which
// emits every complete channel. A byte that completes a bad frame starts a realign
// pass that reads buffer bytes 1 to 24 and copies them down from the first header on.
// req_stall is high while either pass runs. If the receiver stalls, the unpacker
// waits with its next channel and the pass waits too. Reset empties the frame, saturates
// the idle counter, sets the gap to 3 ms and leaves the buffer contents undefined.
module sbus_frame_receiver_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [3:0]  channel_index,
    output logic [10:0] channel_value,
    output logic [7:0]  frame_flags,
    output logic        last_of_frame,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import sfr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_URD   = 6'b000010,
        ST_UMRG  = 6'b000100,
        ST_UEMIT = 6'b001000,
        ST_SRD   = 6'b010000,
        ST_SCHK  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [BUF_AW-1:0] fill_reg, fill_next;
    logic [7:0]        idle_reg, idle_next;
    logic [7:0]        gap_reg;
    logic [BUF_AW-1:0] ptr_reg, ptr_next;
    logic [BUF_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic              found_reg, found_next;

    logic              accept;
    logic [BUF_AW-1:0] pos;
    logic              copy_now;
    logic              ram_we;
    logic [BUF_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    unp_ctrl_t         uctrl;
    unp_stat_t         ustat;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    // A gap longer than configured restarts alignment before the byte is placed.
    assign pos = ((idle_reg > gap_reg) || (fill_reg >= FULL_POS)) ? '0 : fill_reg;

    // During realign, everything from the first header on is copied down.
    assign copy_now = found_reg || (ram_rdata == HDR_BYTE);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        ptr_next    = ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos;
        ram_wdata   = rx_byte;
        uctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_TICK:
                        begin
                            if (idle_reg != IDLE_MAX)
                            begin
                                idle_next = idle_reg + 8'd1;
                            end
                        end
                        REQ_ERR:
                        begin
                            fill_next = '0;
                        end
                        REQ_BYTE:
                        begin
                            idle_next = '0;
                            if ((pos == '0) && (rx_byte != HDR_BYTE))
                            begin
                                fill_next = '0;
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                if (pos != LAST_POS)
                                begin
                                    fill_next = pos + 5'd1;
                                end
                                else if (footer_ok(rx_byte))
                                begin
                                    fill_next   = '0;
                                    ptr_next    = FLAGS_POS;
                                    uctrl.clear = 1'b1;
                                    state_next  = ST_URD;
                                end
                                else
                                begin
                                    ptr_next    = FIRST_POS;
                                    wr_ptr_next = '0;
                                    found_next  = 1'b0;
                                    state_next  = ST_SRD;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_URD:
            begin
                state_next = ST_UMRG;
            end
            ST_UMRG:
            begin
                // The flag byte is read first so that every channel can carry it.
                if (ptr_reg == FLAGS_POS)
                begin
                    uctrl.load_flags = 1'b1;
                    ptr_next         = FIRST_POS;
                end
                else
                begin
                    uctrl.merge = 1'b1;
                    ptr_next    = ptr_reg + 5'd1;
                end
                state_next = ST_UEMIT;
            end
            ST_UEMIT:
            begin
                if (ustat.has_channel)
                begin
                    uctrl.emit = ustat.out_free;
                end
                else if (ptr_reg == FLAGS_POS)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_URD;
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                ram_waddr = wr_ptr_reg;
                ram_wdata = ram_rdata;
                if (copy_now)
                begin
                    ram_we      = 1'b1;
                    wr_ptr_next = wr_ptr_reg + 5'd1;
                    found_next  = 1'b1;
                end
                if (ptr_reg == LAST_POS)
                begin
                    fill_next  = wr_ptr_reg + {4'b0, copy_now};
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 5'd1;
                    state_next = ST_SRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            idle_reg   <= IDLE_MAX;
            gap_reg    <= 8'd3;
            ptr_reg    <= '0;
            wr_ptr_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            idle_reg   <= idle_next;
            ptr_reg    <= ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            found_reg  <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                gap_reg <= cfg_data;
            end
        end
    end

    sfr_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_buf (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(ptr_reg),
        .rd_data(ram_rdata)
    );

    sfr_unpack u_unpack (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (uctrl),
        .rd_data      (ram_rdata),
        .res_stall    (res_stall),
        .stat         (ustat),
        .res_valid    (res_valid),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .frame_flags  (frame_flags),
        .last_of_frame(last_of_frame)
    );

endmodule

>>> sv/sfr_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sfr_unpack.sv
// Bit accumulator that turns frame bytes into 11-bit channels, plus the result register.
// Depends on sfr_pkg.
module sfr_unpack (
    input  logic               clk,
    input  logic               rst_n,
    input  sfr_pkg::unp_ctrl_t ctrl,
    input  logic [7:0]         rd_data,
    input  logic               res_stall,
    output sfr_pkg::unp_stat_t stat,
    output logic               res_valid,
    output logic [3:0]         channel_index,
    output logic [10:0]        channel_value,
    output logic [7:0]         frame_flags,
    output logic               last_of_frame
);
    import sfr_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       flags_reg, flags_next;
    logic [3:0]       ch_reg, ch_next;
    logic             valid_reg, valid_next;
    logic [3:0]       idx_reg;
    logic [10:0]      val_reg;
    logic [7:0]       oflags_reg;
    logic             last_reg;

    always_comb
    begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        ch_next    = ch_reg;
        valid_next = res_stall ? valid_reg : 1'b0;
        if (ctrl.clear)
        begin
            acc_next = '0;
            cnt_next = '0;
            ch_next  = '0;
        end
        else if (ctrl.load_flags)
        begin
            flags_next = rd_data;
        end
        else if (ctrl.merge)
        begin
            // New bits land just above the ones still waiting.
            acc_next = acc_reg | (ACC_W'(rd_data) << cnt_reg);
            cnt_next = cnt_reg + 5'd8;
        end
        else if (ctrl.emit)
        begin
            acc_next   = acc_reg >> CH_BITS;
            cnt_next   = cnt_reg - CH_BITS_CNT;
            ch_next    = ch_reg + 4'd1;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            ch_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        flags_reg <= flags_next;
        if (ctrl.emit)
        begin
            idx_reg    <= ch_reg;
            val_reg    <= acc_reg[CH_BITS-1:0];
            oflags_reg <= flags_reg;
            last_reg   <= (ch_reg == LAST_CH);
        end
    end

    assign stat.has_channel = (cnt_reg >= CH_BITS_CNT);
    assign stat.out_free    = !valid_reg || !res_stall;

    assign res_valid     = valid_reg;
    assign channel_index = idx_reg;
    assign channel_value = val_reg;
    assign frame_flags   = oflags_reg;
    assign last_of_frame = last_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for sbus_frame_receiver_top: drives bytes, ticks and line errors,
// predicts the decoded channel items and compares every result item. Depends on sfr_pkg.
module testbench;
    import sfr_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [7:0] GAP_RESET_MS = 8'd3;
    localparam int SETTLE_CYCLES = 120;
    localparam int LIMIT_CYCLES  = 2000000;

    typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_NOISY} fill_kind_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [10:0] value;
        logic [7:0]  flags;
        logic        last;
    } channel_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [1:0]  req_type = REQ_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [7:0]  frame_flags;
    logic        last_of_frame;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    // Shadow of the receiver state.
    logic [7:0] frame_q [FRAME_BYTES];
    logic [4:0] fill_pos = '0;
    logic [7:0] idle_cnt = IDLE_MAX;
    logic [7:0] gap_ms = GAP_RESET_MS;

    channel_item_t pending_channels[$];
    int items_sent = 0;
    int mismatches = 0;
    bit idle_enable = 1'b1;
    bit stall_enable = 1'b1;
    int hold_cycles = 0;

    sbus_frame_receiver_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .rx_byte       (rx_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .frame_flags   (frame_flags),
        .last_of_frame (last_of_frame),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [10:0] unpack_channel_bits(input int ch);
        logic [10:0] v;
        int pos;
        v = '0;
        for (int i = 0; i < CH_BITS; i++)
        begin
            pos = ch * CH_BITS + i;
            v[i] = frame_q[1 + pos / 8][pos % 8];
        end
        return v;
    endfunction

    function automatic void predict_channels(input logic [1:0] kind, input logic [7:0] b);
        channel_item_t r;
        int hdr_at;
        logic [7:0] foot;
        case (kind)
            REQ_TICK:
                if (idle_cnt != IDLE_MAX)
                    idle_cnt++;
            REQ_ERR:
                fill_pos = '0;
            REQ_BYTE:
            begin
                if (idle_cnt > gap_ms)
                    fill_pos = '0;
                idle_cnt = '0;
                if (fill_pos == 0 && b != HDR_BYTE)
                    return;
                frame_q[fill_pos] = b;
                fill_pos++;
                if (fill_pos != FRAME_BYTES)
                    return;
                foot = frame_q[FRAME_BYTES - 1];
                if (frame_q[0] == HDR_BYTE && (foot == FOOT_BYTE || foot[3:0] == FOOT_NIB))
                begin
                    for (int ch = 0; ch < CH_PER_FRAME; ch++)
                    begin
                        r.index = 4'(ch);
                        r.value = unpack_channel_bits(ch);
                        r.flags = frame_q[FLAGS_POS];
                        r.last  = (ch == CH_PER_FRAME - 1);
                        pending_channels.push_back(r);
                    end
                    fill_pos = '0;
                end
                else
                begin
                    // Slide the frame down to the earliest header after byte 0.
                    hdr_at = 0;
                    for (int i = FRAME_BYTES - 1; i >= 1; i--)
                        if (frame_q[i] == HDR_BYTE)
                            hdr_at = i;
                    if (hdr_at != 0)
                        for (int k = 0; k < FRAME_BYTES - hdr_at; k++)
                            frame_q[k] = frame_q[k + hdr_at];
                    fill_pos = (hdr_at == 0) ? 5'd0 : 5'(FRAME_BYTES - hdr_at);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : channel_checker
        channel_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_channels.size() == 0)
            begin
                $error("unexpected result item: channel_index %0d, channel_value %0d",
                       channel_index, channel_value);
                mismatches++;
            end
            else
            begin
                want = pending_channels.pop_front();
                check_field("channel_index", 32'(want.index), 32'(channel_index));
                check_field("channel_value", 32'(want.value), 32'(channel_value));
                check_field("frame_flags", 32'(want.flags), 32'(frame_flags));
                check_field("last_of_frame", 32'(want.last), 32'(last_of_frame));
            end
        end
    end

    // Receiver side: a long hold-off when requested, else alternating runs or no stall.
    initial
    begin : result_stall_gen
        int run_left;
        bit stalled;
        run_left = 0;
        stalled = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else if (!stall_enable)
                res_stall <= 1'b0;
            else
            begin
                if (run_left == 0)
                begin
                    stalled = !stalled;
                    if (stalled)
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                               : $urandom_range(1, 3);
                    else
                        run_left = $urandom_range(1, 20);
                end
                res_stall <= stalled;
                run_left--;
            end
        end
    end

    initial
    begin : watchdog
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("tb: failure");
        $finish;
    end

    // Leaves valid high after acceptance so the next item can follow back to back.
    task automatic send_item(input logic [1:0] kind, input logic [7:0] b);
        @(negedge clk);
        req_valid <= 1'b1;
        req_type  <= kind;
        rx_byte   <= b;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        predict_channels(kind, b);
        if (kind != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic idle_req(input int cycles);
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_paced(input logic [1:0] kind, input logic [7:0] b);
        int r;
        if (idle_enable)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                idle_req($urandom_range(20, 60));
            else if (r >= 65)
                idle_req($urandom_range(1, 4));
        end
        send_item(kind, b);
    endtask

    task automatic wait_drained();
        idle_req(1);
        while (pending_channels.size() != 0)
            @(posedge clk);
        // A realign pass may still be running after the last result item.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [7:0] ms);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ms;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        gap_ms = ms;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input fill_kind_t fill, input logic [7:0] flags,
                              input logic [7:0] footer);
        logic [7:0] b;
        send_paced(REQ_BYTE, HDR_BYTE);
        for (int i = FIRST_POS; i < FLAGS_POS; i++)
        begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                default:   b = ($urandom_range(0, 15) == 0) ? HDR_BYTE
                                                            : 8'($urandom_range(0, 255));
            endcase
            if (fill == FILL_NOISY && $urandom_range(0, 39) == 0)
                send_paced(REQ_TICK, 8'($urandom_range(0, 255)));
            send_paced(REQ_BYTE, b);
        end
        send_paced(REQ_BYTE, flags);
        send_paced(REQ_BYTE, footer);
    endtask

    task automatic test_idle_events();
        send_paced(REQ_TICK, 8'h00);
        send_paced(REQ_ERR, 8'hFF);
        send_paced(REQ_UNUSED, 8'hFF);
        // Bytes other than the header are dropped while the frame is empty.
        send_paced(REQ_BYTE, 8'h00);
        send_paced(REQ_BYTE, 8'hFF);
        send_paced(REQ_BYTE, 8'h0E);
        send_paced(REQ_BYTE, 8'hF0);
    endtask

    task automatic test_frame_extremes();
        send_frame(FILL_ONES, 8'hFF, FOOT_BYTE);
        send_frame(FILL_ZERO, 8'h00, 8'hF4);
    endtask

    task automatic test_bad_footer();
        send_paced(REQ_BYTE, HDR_BYTE);
        for (int i = FIRST_POS; i < LAST_POS; i++)
            send_paced(REQ_BYTE, (i == 6) ? HDR_BYTE : 8'(i));
        send_paced(REQ_BYTE, 8'h40);
        // The realigned frame is completed by the following bytes.
        repeat (5) send_paced(REQ_BYTE, 8'hA5);
        send_paced(REQ_BYTE, FOOT_BYTE);
        // No header anywhere in the rejected frame: it is dropped entirely.
        send_frame(FILL_ZERO, 8'h00, 8'h01);
    endtask

    task automatic test_line_error();
        send_paced(REQ_BYTE, HDR_BYTE);
        repeat (3) send_paced(REQ_BYTE, 8'h77);
        send_paced(REQ_ERR, 8'h00);
        send_frame(FILL_RANDOM, 8'h3C, FOOT_BYTE);
    endtask

    task automatic test_gap_restart();
        write_gap(8'd2);
        send_paced(REQ_BYTE, HDR_BYTE);
        repeat (10) send_paced(REQ_BYTE, 8'h3C);
        repeat (2) send_paced(REQ_TICK, 8'h00);
        repeat (14) send_paced(REQ_BYTE, 8'h04);
        // One tick too many: the partial frame is abandoned at the next header.
        send_paced(REQ_BYTE, HDR_BYTE);
        repeat (3) send_paced(REQ_BYTE, 8'hC3);
        repeat (3) send_paced(REQ_TICK, 8'hFF);
        send_frame(FILL_RANDOM, 8'h66, 8'h24);
    endtask

    task automatic test_gap_disabled();
        // With the gap at its maximum, a long pause never restarts the frame.
        write_gap(8'd255);
        send_paced(REQ_BYTE, HDR_BYTE);
        repeat (3) send_paced(REQ_BYTE, 8'h21);
        repeat (30) send_paced(REQ_TICK, 8'($urandom_range(0, 255)));
        repeat (20) send_paced(REQ_BYTE, 8'($urandom_range(0, 255)));
        send_paced(REQ_BYTE, FOOT_BYTE);
        write_gap(GAP_RESET_MS);
    endtask

    task automatic test_result_backpressure();
        idle_enable = 1'b0;
        hold_cycles = 400;
        repeat (2) send_frame(FILL_RANDOM, 8'($urandom_range(0, 255)), FOOT_BYTE);
        wait_drained();
        idle_enable = 1'b1;
    endtask

    task automatic random_burst(input int item_goal);
        int start_items;
        int pick;
        logic [7:0] footer;
        start_items = items_sent;
        while (items_sent - start_items < item_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                case ($urandom_range(0, 2))
                    0:       footer = FOOT_BYTE;
                    1:       footer = {4'($urandom_range(0, 15)), FOOT_NIB};
                    default: footer = 8'($urandom_range(0, 255));
                endcase
                send_frame(FILL_NOISY, 8'($urandom_range(0, 255)), footer);
            end
            else if (pick < 65)
            begin
                send_paced(REQ_BYTE, HDR_BYTE);
                repeat ($urandom_range(1, 23))
                    send_paced(REQ_BYTE, 8'($urandom_range(0, 255)));
            end
            else if (pick < 80)
                repeat ($urandom_range(1, 6))
                    send_paced(REQ_TICK, 8'($urandom_range(0, 255)));
            else if (pick < 88)
                send_paced(REQ_ERR, 8'($urandom_range(0, 255)));
            else if (pick < 95)
                repeat ($urandom_range(1, 5))
                    send_paced(REQ_BYTE, 8'($urandom_range(0, 255)));
            else
                send_paced(REQ_UNUSED, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        write_gap(8'd0);
        random_burst(20);
        // One stretch runs with neither side idling.
        idle_enable = 1'b0;
        stall_enable = 1'b0;
        write_gap(8'd255);
        random_burst(20);
        idle_enable = 1'b1;
        stall_enable = 1'b1;
        write_gap(8'($urandom_range(1, 254)));
        random_burst(20);
        write_gap(GAP_RESET_MS);
        random_burst(20);
    endtask

    initial
    begin : run_tests
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_events();
        test_frame_extremes();
        test_bad_footer();
        test_line_error();
        test_gap_restart();
        test_gap_disabled();
        test_result_backpressure();
        test_random_traffic();
        wait_drained();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
sv/sfr_pkg.sv
sv/sfr_ram.sv
sv/sfr_unpack.sv
sv/sbus_frame_receiver_top.sv
tb/testbench.sv
